@@ sv/assert_macros.svh @@
// Assertion macros used by the execute unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define SMEU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SMEU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SMEU_ASSERT(lbl, prop, msg)
`define SMEU_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ sv/smeu_pkg.sv @@
package smeu_pkg;

  localparam int STACK_DEPTH   = 256;
  localparam int PROGRAM_DEPTH = 256;
  localparam int WORD_WIDTH    = 32;

  localparam int SP_W     = $clog2(STACK_DEPTH);
  localparam int DEPTH_W  = SP_W + 1;
  localparam int IP_W     = $clog2(PROGRAM_DEPTH);
  localparam int FUNC_W   = 4;
  localparam int OPND_W   = 32;
  localparam int STATUS_W = 3;
  localparam int TOP_W    = 32;
  localparam int CNT_W    = $clog2(WORD_WIDTH);

  localparam int IN_TDATA_W  = ((FUNC_W + OPND_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((IP_W + TOP_W + DEPTH_W + STATUS_W + 7) / 8) * 8;

  typedef logic signed [WORD_WIDTH-1:0] word_t;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH = 4'd0,
    FN_POP  = 4'd1,
    FN_ADD  = 4'd2,
    FN_SUB  = 4'd3,
    FN_MUL  = 4'd4,
    FN_DIV  = 4'd5,
    FN_JMP  = 4'd6,
    FN_JNZ  = 4'd7,
    FN_HALT = 4'd8
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_HALTED    = 3'd1,
    STAT_UNKNOWN   = 3'd2,
    STAT_OVERFLOW  = 3'd3,
    STAT_UNDERFLOW = 3'd4,
    STAT_DIVZERO   = 3'd5,
    STAT_BADTARGET = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_EXEC,
    ST_ALU,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef struct packed {
    logic  done;
    word_t result;
  } alu_rsp_t;

endpackage

@@ sv/stack_machine_execute_unit.sv @@
// Stack machine execute unit: one instruction per input beat, one result beat per instruction.
// Each instruction runs idle, decode, output; pop and jnz on a zero top add an execute step,
// add, sub, mul and div add execute and arithmetic steps; div waits on the serial divide.
// Faults and a halted machine go from decode to output; new beats are taken only in idle.
// Stack words sit in a single-port-read RAM with a registered read; the top is held in a flop.
// Reset (rst, synchronous): depth, instruction pointer and halted flag clear; RAM is not cleared.
`include "assert_macros.svh"

module stack_machine_execute_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // s_tdata, lowest bit up: func[3:0], operand[35:4], zero pad to 40 bits
  input  logic [smeu_pkg::IN_TDATA_W-1:0]      s_tdata,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // m_tdata, lowest bit up: next_ip[7:0], top_value[39:8], stack_depth[48:40],
  // status[51:49], zero pad to 56 bits
  output logic [smeu_pkg::OUT_TDATA_W-1:0]     m_tdata
);

  localparam int SP_W    = smeu_pkg::SP_W;
  localparam int DEPTH_W = smeu_pkg::DEPTH_W;
  localparam int IP_W    = smeu_pkg::IP_W;
  localparam int OPND_W  = smeu_pkg::OPND_W;
  localparam int FUNC_W  = smeu_pkg::FUNC_W;
  localparam int W       = smeu_pkg::WORD_WIDTH;

  // Control state
  smeu_pkg::state_t          state, state_next;
  logic [DEPTH_W-1:0]        depth, depth_next;
  logic [IP_W-1:0]           ip, ip_next;
  logic                      halted, halted_next;

  // Payload
  smeu_pkg::word_t           top, top_next;
  smeu_pkg::status_t         status, status_next;
  smeu_pkg::func_t           func_q;
  logic signed [OPND_W-1:0]  operand_q;

  // Stack RAM ports
  logic                      ram_we;
  logic [SP_W-1:0]           ram_waddr;
  smeu_pkg::word_t           ram_wdata;
  logic [SP_W-1:0]           ram_raddr;
  smeu_pkg::word_t           ram_rdata;

  smeu_pkg::alu_req_t        alu_req;
  smeu_pkg::alu_rsp_t        alu_rsp;

  logic                      out_load;
  logic [IP_W-1:0]           ip_inc;
  logic                      target_ok;
  logic [SP_W-1:0]           below_top;
  smeu_pkg::word_t           push_word;
  smeu_pkg::word_t           top_out;

  smeu_ram #(
    .WIDTH(W),
    .DEPTH(smeu_pkg::STACK_DEPTH)
  ) u_stack (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  smeu_alu u_alu (
    .clk(clk),
    .rst(rst),
    .req(alu_req),
    .a  (ram_rdata),
    .b  (top),
    .rsp(alu_rsp)
  );

  assign s_tready  = (state == smeu_pkg::ST_IDLE);
  assign ip_inc    = (ip == IP_W'(smeu_pkg::PROGRAM_DEPTH - 1)) ? '0 : ip + 1'b1;
  // a jump target must be non-negative and inside the program
  assign target_ok = !operand_q[OPND_W-1] &&
                     ($unsigned(operand_q) < OPND_W'(smeu_pkg::PROGRAM_DEPTH));
  // second word from the top; meaningful only while at least two words are held
  assign below_top = SP_W'(depth - DEPTH_W'(2));
  assign push_word = W'(operand_q);
  assign top_out   = (depth != '0) ? top : '0;

  always_comb begin
    state_next  = state;
    depth_next  = depth;
    ip_next     = ip;
    halted_next = halted;
    top_next    = top;
    status_next = status;
    ram_we      = 1'b0;
    ram_waddr   = depth[SP_W-1:0];
    ram_wdata   = push_word;
    ram_raddr   = below_top;
    alu_req     = '{start: 1'b0, op: smeu_pkg::ALU_ADD};
    out_load    = 1'b0;

    case (state)
      smeu_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          state_next = smeu_pkg::ST_DECODE;
        end
      end

      smeu_pkg::ST_DECODE: begin
        // faults answer at once and leave the state alone, but an unknown opcode halts
        status_next = smeu_pkg::STAT_OK;
        state_next  = smeu_pkg::ST_OUT;
        if (halted) begin
          status_next = smeu_pkg::STAT_HALTED;
        end else begin
          case (func_q)
            smeu_pkg::FN_PUSH: begin
              if (depth >= DEPTH_W'(smeu_pkg::STACK_DEPTH)) begin
                status_next = smeu_pkg::STAT_OVERFLOW;
              end else begin
                ram_we     = 1'b1;
                top_next   = push_word;
                depth_next = depth + 1'b1;
                ip_next    = ip_inc;
              end
            end
            smeu_pkg::FN_POP: begin
              if (depth == '0) begin
                status_next = smeu_pkg::STAT_UNDERFLOW;
              end else begin
                state_next = smeu_pkg::ST_EXEC;
              end
            end
            smeu_pkg::FN_ADD, smeu_pkg::FN_SUB, smeu_pkg::FN_MUL, smeu_pkg::FN_DIV: begin
              if (depth < DEPTH_W'(2)) begin
                status_next = smeu_pkg::STAT_UNDERFLOW;
              end else if (func_q == smeu_pkg::FN_DIV && top == '0) begin
                status_next = smeu_pkg::STAT_DIVZERO;
              end else begin
                state_next = smeu_pkg::ST_EXEC;
              end
            end
            smeu_pkg::FN_JMP: begin
              if (target_ok) begin
                ip_next = operand_q[IP_W-1:0];
              end else begin
                status_next = smeu_pkg::STAT_BADTARGET;
              end
            end
            smeu_pkg::FN_JNZ: begin
              if (depth == '0) begin
                status_next = smeu_pkg::STAT_UNDERFLOW;
              end else if (top != '0) begin
                if (target_ok) begin
                  ip_next = operand_q[IP_W-1:0];
                end else begin
                  status_next = smeu_pkg::STAT_BADTARGET;
                end
              end else begin
                // zero top: drop it, whatever the target
                state_next = smeu_pkg::ST_EXEC;
              end
            end
            smeu_pkg::FN_HALT: begin
              halted_next = 1'b1;
              status_next = smeu_pkg::STAT_HALTED;
            end
            default: begin
              halted_next = 1'b1;
              status_next = smeu_pkg::STAT_UNKNOWN;
            end
          endcase
        end
      end

      smeu_pkg::ST_EXEC: begin
        // RAM data now holds the word below the top
        case (func_q)
          smeu_pkg::FN_ADD: begin
            alu_req    = '{start: 1'b1, op: smeu_pkg::ALU_ADD};
            state_next = smeu_pkg::ST_ALU;
          end
          smeu_pkg::FN_SUB: begin
            alu_req    = '{start: 1'b1, op: smeu_pkg::ALU_SUB};
            state_next = smeu_pkg::ST_ALU;
          end
          smeu_pkg::FN_MUL: begin
            alu_req    = '{start: 1'b1, op: smeu_pkg::ALU_MUL};
            state_next = smeu_pkg::ST_ALU;
          end
          smeu_pkg::FN_DIV: begin
            alu_req    = '{start: 1'b1, op: smeu_pkg::ALU_DIV};
            state_next = smeu_pkg::ST_ALU;
          end
          default: begin
            // pop, and jnz on a zero top
            top_next   = ram_rdata;
            depth_next = depth - 1'b1;
            ip_next    = ip_inc;
            state_next = smeu_pkg::ST_OUT;
          end
        endcase
      end

      smeu_pkg::ST_ALU: begin
        if (alu_rsp.done) begin
          ram_we     = 1'b1;
          ram_waddr  = below_top;
          ram_wdata  = alu_rsp.result;
          top_next   = alu_rsp.result;
          depth_next = depth - 1'b1;
          ip_next    = ip_inc;
          state_next = smeu_pkg::ST_OUT;
        end
      end

      smeu_pkg::ST_OUT: begin
        // hold until the output register is free
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = smeu_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = smeu_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= smeu_pkg::ST_IDLE;
      depth    <= '0;
      ip       <= '0;
      halted   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state  <= state_next;
      depth  <= depth_next;
      ip     <= ip_next;
      halted <= halted_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    top    <= top_next;
    status <= status_next;
    if (s_tvalid && s_tready) begin
      func_q    <= smeu_pkg::func_t'(s_tdata[FUNC_W-1:0]);
      operand_q <= s_tdata[FUNC_W +: OPND_W];
    end
    if (out_load) begin
      m_tdata <= smeu_pkg::OUT_TDATA_W'({status, depth, smeu_pkg::TOP_W'(top_out), ip});
    end
  end

  `SMEU_ASSERT(a_depth_bound, (depth <= DEPTH_W'(smeu_pkg::STACK_DEPTH)), "stack depth beyond capacity")
  `SMEU_ASSERT(a_halt_sticks, (halted |=> halted), "halted flag cleared without reset")
  `SMEU_ASSERT(a_depth_step, ((state != smeu_pkg::ST_DECODE && state != smeu_pkg::ST_EXEC && state != smeu_pkg::ST_ALU) |=> $stable(depth)), "depth moved outside execution")
  `SMEU_ASSERT(a_alu_done, (alu_rsp.done |-> state == smeu_pkg::ST_ALU), "arithmetic result with no operation waiting")
  `SMEU_ASSERT(a_accept_decode, ((s_tvalid && s_tready) |=> state == smeu_pkg::ST_DECODE), "accepted beat not decoded")

endmodule

@@ sv/smeu_ram.sv @@
module smeu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/smeu_alu.sv @@
// Shared arithmetic unit: add, subtract and multiply with a registered result,
// signed division by restoring steps, one quotient bit per cycle.
module smeu_alu (
  input  logic               clk,
  input  logic               rst,
  input  smeu_pkg::alu_req_t req,
  input  smeu_pkg::word_t    a,
  input  smeu_pkg::word_t    b,
  output smeu_pkg::alu_rsp_t rsp
);

  localparam int W = smeu_pkg::WORD_WIDTH;

  logic                      running;
  logic                      done;
  logic                      div_mode;
  logic                      neg;
  logic [smeu_pkg::CNT_W-1:0] cnt;
  logic [W-1:0]              res;
  logic [W-1:0]              quo;
  logic [W-1:0]              rem;
  logic [W-1:0]              dvs;
  logic [W:0]                shifted;
  logic                      fits;

  assign shifted = {rem, quo[W-1]};
  assign fits    = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        running <= (req.op == smeu_pkg::ALU_DIV);
        done    <= (req.op != smeu_pkg::ALU_DIV);
      end else if (running && cnt == '0) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      div_mode <= (req.op == smeu_pkg::ALU_DIV);
      case (req.op)
        smeu_pkg::ALU_ADD: res <= a + b;
        smeu_pkg::ALU_SUB: res <= a - b;
        smeu_pkg::ALU_MUL: res <= W'(a * b);
        default: begin
          // take magnitudes; fix the sign at the end
          quo <= a[W-1] ? W'(0) - a : a;
          dvs <= b[W-1] ? W'(0) - b : b;
          rem <= '0;
          neg <= a[W-1] ^ b[W-1];
          cnt <= smeu_pkg::CNT_W'(W - 1);
        end
      endcase
    end else if (running) begin
      rem <= fits ? W'(shifted - {1'b0, dvs}) : shifted[W-1:0];
      quo <= {quo[W-2:0], fits};
      cnt <= cnt - 1'b1;
    end
  end

  assign rsp.done   = done;
  assign rsp.result = div_mode ? (neg ? W'(0) - quo : quo) : res;

endmodule

@@ bench/tb_stack_machine_execute_unit.sv @@
`timescale 1ns / 100ps

module tb_stack_machine_execute_unit;
  import smeu_pkg::*;

  localparam int RANDOM_ITEMS = 600;
  localparam int STALL_LIMIT  = 2000;  // cycles with no beat on either side
  localparam int DRAIN_CYCLES = 40;    // longer than the slowest instruction (div)
  localparam int HOLD_OFF     = 300;   // one long receiver stall
  localparam int RES_W        = IP_W + TOP_W + DEPTH_W + STATUS_W;

  // Instruction beat, lowest bits first: func, then operand
  typedef struct packed {
    logic [OPND_W-1:0] operand;
    logic [FUNC_W-1:0] func;
  } instr_t;

  // Result beat, lowest bits first: next_ip, top_value, stack_depth, status
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DEPTH_W-1:0]  stack_depth;
    word_t               top_value;
    logic [IP_W-1:0]     next_ip;
  } vm_result_t;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  stack_machine_execute_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Machine state as the bench sees it: operand stack, depth, ip, halted flag.
  // ---------------------------------------------------------------------------
  word_t           vm_stack [STACK_DEPTH];
  int unsigned     vm_depth  = 0;
  logic [IP_W-1:0] vm_ip     = '0;
  bit              vm_halted = 1'b0;

  // Execute one instruction against the machine state and return the beat the
  // block should answer with. Any fault but an unknown opcode (which halts) leaves the state exactly as it was.
  function automatic vm_result_t execute_instr(instr_t ins);
    vm_result_t          res;
    logic [STATUS_W-1:0] st;
    logic [IP_W-1:0]     step_ip;
    word_t               lhs, rhs, val;
    longint              quo;
    bit                  target_ok;
    st        = STAT_OK;
    step_ip   = vm_ip + 1'b1;
    target_ok = (ins.operand[OPND_W-1:IP_W] == '0);
    if (vm_halted) begin
      st = STAT_HALTED;
    end else begin
      case (ins.func)
        FN_PUSH: begin
          if (vm_depth >= STACK_DEPTH) begin
            st = STAT_OVERFLOW;
          end else begin
            vm_stack[SP_W'(vm_depth)] = ins.operand;
            vm_depth++;
            vm_ip = step_ip;
          end
        end
        FN_POP: begin
          if (vm_depth == 0) begin
            st = STAT_UNDERFLOW;
          end else begin
            vm_depth--;
            vm_ip = step_ip;
          end
        end
        FN_ADD, FN_SUB, FN_MUL, FN_DIV: begin
          if (vm_depth < 2) begin
            st = STAT_UNDERFLOW;
          end else begin
            lhs = vm_stack[SP_W'(vm_depth-2)];
            rhs = vm_stack[SP_W'(vm_depth-1)];
            case (ins.func)
              FN_ADD:  val = lhs + rhs;
              FN_SUB:  val = lhs - rhs;
              FN_MUL:  val = lhs * rhs;
              default: begin
                // widen first: the most negative word over minus one must wrap
                quo = (rhs == 0) ? 64'sd0 : longint'(lhs) / longint'(rhs);
                val = quo[WORD_WIDTH-1:0];
              end
            endcase
            if (ins.func == FN_DIV && rhs == 0) begin
              st = STAT_DIVZERO;
            end else begin
              vm_stack[SP_W'(vm_depth-2)] = val;
              vm_depth--;
              vm_ip = step_ip;
            end
          end
        end
        FN_JMP: begin
          if (!target_ok) st = STAT_BADTARGET;
          else vm_ip = ins.operand[IP_W-1:0];
        end
        FN_JNZ: begin
          if (vm_depth == 0) begin
            st = STAT_UNDERFLOW;
          end else if (vm_stack[SP_W'(vm_depth-1)] != 0) begin
            if (!target_ok) st = STAT_BADTARGET;
            else vm_ip = ins.operand[IP_W-1:0];
          end else begin
            // zero top: drop it and fall through, whatever the target
            vm_depth--;
            vm_ip = step_ip;
          end
        end
        FN_HALT: begin
          vm_halted = 1'b1;
          st = STAT_HALTED;
        end
        default: begin
          vm_halted = 1'b1;
          st = STAT_UNKNOWN;
        end
      endcase
    end
    res.next_ip     = vm_ip;
    res.stack_depth = DEPTH_W'(vm_depth);
    res.top_value   = (vm_depth > 0) ? vm_stack[SP_W'(vm_depth-1)] : '0;
    res.status      = st;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Program generation. A rough depth estimate steers the random part towards
  // instructions that get past the underflow checks.
  // ---------------------------------------------------------------------------
  instr_t     instr_q [$];      // instructions still to be offered
  vm_result_t vm_result_q [$];  // predicted result beats, oldest first
  int         gen_depth = 0;

  function automatic void emit(logic [FUNC_W-1:0] f, logic [OPND_W-1:0] v);
    instr_t ins;
    ins.func    = f;
    ins.operand = v;
    instr_q.push_back(ins);
    case (f)
      FN_PUSH: if (gen_depth < STACK_DEPTH) gen_depth++;
      FN_POP:  if (gen_depth > 0) gen_depth--;
      FN_ADD, FN_SUB, FN_MUL, FN_DIV: if (gen_depth >= 2) gen_depth--;
      default: ;
    endcase
  endfunction

  // Mix of corner words and small signed values (for division and zero tops)
  function automatic logic [OPND_W-1:0] rand_word();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'h8000_0000;
      2:       return 32'h7fff_ffff;
      3:       return 32'hffff_ffff;
      4, 5:    return int'($urandom_range(0, 40)) - 20;
      default: return $urandom();
    endcase
  endfunction

  // Mostly valid targets; now and then past the end or negative
  function automatic logic [OPND_W-1:0] rand_target();
    if ($urandom_range(0, 7) != 0) return $urandom_range(0, PROGRAM_DEPTH - 1);
    if ($urandom_range(0, 1) != 0) return PROGRAM_DEPTH + $urandom_range(0, 1000);
    return $urandom() | 32'h8000_0000;
  endfunction

  // Well-formed run: keep at least two words about, then mix every operation but halt
  function automatic void gen_program_run(int len);
    for (int i = 0; i < len; i++) begin
      if (gen_depth < 2 || $urandom_range(0, 3) == 0) begin
        emit(FN_PUSH, rand_word());
      end else begin
        case ($urandom_range(0, 10))
          0:       emit(FN_POP, $urandom());
          1, 2:    emit(FN_ADD, $urandom());
          3:       emit(FN_SUB, $urandom());
          4:       emit(FN_MUL, $urandom());
          5:       emit(FN_DIV, $urandom());
          6:       emit(FN_JMP, rand_target());
          7: begin
            // zero on top: jnz must pop and fall through
            emit(FN_PUSH, '0);
            emit(FN_JNZ, rand_target());
            gen_depth--;
          end
          default: emit(FN_JNZ, rand_target());
        endcase
      end
    end
  endfunction

  // Fill the stack to the brim, push past it, then unwind most of the way
  function automatic void gen_fill_and_unwind();
    while (gen_depth < STACK_DEPTH) emit(FN_PUSH, rand_word());
    repeat (6) emit(FN_PUSH, $urandom());
    while (gen_depth > 8) begin
      case ($urandom_range(0, 4))
        0:       emit(FN_POP, $urandom());
        1:       emit(FN_SUB, $urandom());
        2:       emit(FN_MUL, $urandom());
        3:       emit(FN_DIV, $urandom());
        default: emit(FN_ADD, $urandom());
      endcase
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length with random gaps. Hold the beat until the
  // block takes it; the acceptance flag comes from the monitor at the rising edge.
  // ---------------------------------------------------------------------------
  bit     in_beat_seen = 1'b0;
  bit     offering     = 1'b0;
  instr_t cur_instr    = '0;
  int     gap_left     = 0;
  int     burst_left   = 0;

  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
    end else begin
      if (in_beat_seen) begin
        in_beat_seen = 1'b0;
        offering     = 1'b0;
      end
      if (!offering) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (instr_q.size() > 0) begin
          cur_instr = instr_q.pop_front();
          offering  = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
          end
        end
      end
      s_tvalid <= offering;
      s_tdata  <= IN_TDATA_W'(cur_instr);
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: a mode picked per random-length stretch (always ready, coin toss,
  // mostly stalled, mostly ready), plus one long hold-off once results flow,
  // so that the block backs up and stalls its input.
  // ---------------------------------------------------------------------------
  int results_seen = 0;
  int rx_mode      = 0;
  int rx_left      = 0;
  int hold_left    = 0;
  bit hold_done    = 1'b0;

  always @(negedge clk) begin
    logic rdy;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (!hold_done && results_seen >= 150) begin
        hold_left = HOLD_OFF;
        hold_done = 1'b1;
      end
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(16, 96);
      end
      rx_left--;
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        case (rx_mode)
          0:       rdy = 1'b1;
          1:       rdy = ($urandom_range(0, 1) != 0);
          2:       rdy = ($urandom_range(0, 3) == 0);
          default: rdy = ($urandom_range(0, 7) != 0);
        endcase
      end
      m_tready <= rdy;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on every input beat, check every result beat against the
  // oldest prediction, and count cycles in which nothing moves.
  // ---------------------------------------------------------------------------
  int beats_in     = 0;
  int mismatches   = 0;
  int stall_cycles = 0;

  task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    vm_result_t got, want;
    if (rst) begin
      stall_cycles = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = vm_result_t'(m_tdata[RES_W-1:0]);
        if (vm_result_q.size() == 0) begin
          mismatches++;
          $display("%0t: result beat with none expected: expected nothing, actual %h",
                   $time, m_tdata);
        end else begin
          want = vm_result_q.pop_front();
          check_field("next_ip", 32'(want.next_ip), 32'(got.next_ip));
          check_field("top_value", want.top_value, got.top_value);
          check_field("stack_depth", 32'(want.stack_depth), 32'(got.stack_depth));
          check_field("status", 32'(want.status), 32'(got.status));
        end
        results_seen++;
      end
      if (s_tvalid && s_tready) begin
        vm_result_q.push_back(execute_instr(instr_t'(s_tdata[FUNC_W+OPND_W-1:0])));
        beats_in++;
        in_beat_seen = 1'b1;
      end
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) stall_cycles = 0;
      else stall_cycles++;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int  total;
    int  directed_n;
    bit  fill_done;

    // Empty stack: every consumer underflows
    emit(FN_POP, 32'h0000_0000);
    emit(FN_ADD, 32'hffff_ffff);
    emit(FN_JNZ, 32'd3);
    // Largest positive plus one wraps; a lone word cannot be subtracted from
    emit(FN_PUSH, 32'h7fff_ffff);
    emit(FN_SUB, 32'h0000_0000);
    emit(FN_PUSH, 32'h0000_0001);
    emit(FN_ADD, 32'h0000_0000);
    // Most negative over minus one wraps to itself, then a zero divisor
    emit(FN_PUSH, 32'hffff_ffff);
    emit(FN_DIV, 32'h0000_0000);
    emit(FN_PUSH, 32'h0000_0000);
    emit(FN_DIV, 32'h0000_0000);
    // Zero top: jnz pops even with a negative target
    emit(FN_JNZ, 32'hffff_ffff);
    // -7 / 2 truncates toward zero; product wraps to zero
    emit(FN_PUSH, 32'hffff_fff9);
    emit(FN_PUSH, 32'd2);
    emit(FN_DIV, 32'h0000_0000);
    emit(FN_PUSH, 32'h0001_0000);
    emit(FN_PUSH, 32'h0001_0000);
    emit(FN_MUL, 32'h0000_0000);
    emit(FN_SUB, 32'h0000_0000);
    // Jump to the last slot, one past it, and a negative target
    emit(FN_JMP, 32'd255);
    emit(FN_JMP, 32'd256);
    emit(FN_JMP, 32'h8000_0000);
    // Nonzero top: bad target faults, good target is taken
    emit(FN_PUSH, 32'd5);
    emit(FN_JNZ, 32'd300);
    emit(FN_JNZ, 32'd17);

    directed_n = instr_q.size();
    fill_done  = 1'b0;
    while (instr_q.size() < directed_n + RANDOM_ITEMS) begin
      if (!fill_done && instr_q.size() > 100) begin
        gen_fill_and_unwind();
        fill_done = 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
        // noise: any non-halting operation with any operand, whatever the depth
        repeat ($urandom_range(3, 8)) emit(FUNC_W'($urandom_range(0, 7)), $urandom());
      end else begin
        gen_program_run($urandom_range(4, 20));
      end
    end

    // Unknown opcode halts the machine; after it halt and everything else
    // answers as halted
    emit(FUNC_W'($urandom_range(9, 15)), $urandom());
    emit(FN_HALT, $urandom());
    repeat (8) emit(FUNC_W'($urandom_range(0, 15)), $urandom());
    total = instr_q.size();

    repeat (5) @(negedge clk);
    rst <= 1'b0;

    while ((beats_in < total || vm_result_q.size() != 0) && stall_cycles < STALL_LIMIT)
      @(negedge clk);

    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles, %0d results outstanding",
               $time, stall_cycles, vm_result_q.size());
      $display("RESULT: ERROR");
    end else begin
      // let any stray result beat show up before the verdict
      repeat (DRAIN_CYCLES) @(negedge clk);
      if (mismatches == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
